// ===== src/quicksort_sorter_defines.svh =====
// ----------------------------------------------------------------------------
// quicksort_sorter_defines.svh
// Assertion macros shared by the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_SORTER_DEFINES_SVH
`define QUICKSORT_SORTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define QSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define QSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/qss_pkg.sv =====
// ----------------------------------------------------------------------------
// qss_pkg
// Sizes and types for the quicksort sorter.
// ----------------------------------------------------------------------------
package qss_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  // Pending subranges are disjoint and at least two long.
  localparam int STACK_DEPTH = STORE_DEPTH / 2;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

endpackage

// ===== src/quicksort_sorter.sv =====
// Operation: one input word is taken per cycle while collecting; after the
//   word marked last, ranges are partitioned one by one (ordered input is the
//   worst case), then each result is read, loaded and held until taken.
// Throughput: the store has one read and one write port; input is held off
//   from the word marked last until the final result word is taken.
// Reset: synchronous, active low; clears sequencer, counts and flags only.
// ----------------------------------------------------------------------------
// quicksort_sorter
// Collects signed words, sorts them in place by quicksort and streams them out.
// ----------------------------------------------------------------------------
`include "quicksort_sorter_defines.svh"

module quicksort_sorter (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last word of the set
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // end_of_set
  output logic        out_tuser   // [0] overflow
);

  localparam int IW  = qss_pkg::IDX_W;
  localparam int CW  = qss_pkg::CNT_W;
  localparam int SPW = qss_pkg::SP_W;
  localparam int SIW = qss_pkg::STK_IDX_W;
  localparam int DW  = qss_pkg::DATA_W;

  typedef enum logic [3:0] {
    ST_COLLECT,   // take words into the store
    ST_INIT,      // push the whole set as the first range
    ST_POP,       // pop a range or go emit
    ST_LOAD,      // latch popped range, read its pivot
    ST_PIVOT,     // latch pivot
    ST_RD_HI,     // read from the high end
    ST_CK_HI,     // compare high element against pivot
    ST_RD_LO,     // read from the low end
    ST_CK_LO,     // compare low element against pivot
    ST_PLACE,     // drop pivot into the hole, push left part
    ST_PUSH_B,    // push right part
    ST_EMIT_RD,   // read next sorted word
    ST_EMIT_LD,   // load output register
    ST_EMIT_WT    // hold word until taken
  } state_t;

  // Element store and range stack
  logic signed [DW-1:0] elem_mem [qss_pkg::STORE_DEPTH];
  qss_pkg::range_t      stk_mem  [qss_pkg::STACK_DEPTH];

  logic signed [DW-1:0] mem_q;
  qss_pkg::range_t      stk_q;

  logic                 mem_re, mem_we;
  logic [IW-1:0]        mem_raddr, mem_waddr;
  logic signed [DW-1:0] mem_wdata;
  logic                 stk_re, stk_we;
  logic [SIW-1:0]       stk_raddr, stk_waddr;
  qss_pkg::range_t      stk_wdata;

  // Sequencer state
  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [SPW-1:0]       sp_r, sp_nxt;
  logic                 drop_r, drop_nxt;
  logic [IW-1:0]        lo_r, lo_nxt;
  logic [IW-1:0]        hi_r, hi_nxt;
  logic [IW-1:0]        rlo_r, rlo_nxt;
  logic [IW-1:0]        rhi_r, rhi_nxt;
  logic signed [DW-1:0] pivot_r, pivot_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DW-1:0]        out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic                 sp_full;
  logic [CW-1:0]        left_len, right_len;

  assign in_tready  = (state_r == ST_COLLECT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  assign sp_full   = (sp_r >= SPW'(qss_pkg::STACK_DEPTH));
  // Distance of the pivot slot from either end of the current range
  assign left_len  = CW'(lo_r) - CW'(rlo_r);
  assign right_len = CW'(rhi_r) - CW'(lo_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sp_nxt        = sp_r;
    drop_nxt      = drop_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    rlo_nxt       = rlo_r;
    rhi_nxt       = rhi_r;
    pivot_nxt     = pivot_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    mem_re    = 1'b0;
    mem_raddr = lo_r;
    mem_we    = 1'b0;
    mem_waddr = lo_r;
    mem_wdata = mem_q;
    stk_re    = 1'b0;
    stk_raddr = SIW'(sp_r - SPW'(1));
    stk_we    = 1'b0;
    stk_waddr = sp_r[SIW-1:0];
    stk_wdata = '{lo: rlo_r, hi: rhi_r};

    unique case (state_r)
      ST_COLLECT: begin
        if (in_tvalid) begin
          // Store while room is left, else drop and flag the set
          if (cnt_r < CW'(qss_pkg::STORE_DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[IW-1:0];
            mem_wdata = in_tdata;
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_INIT;
          end
        end
      end

      ST_INIT: begin
        sp_nxt = '0;
        if (cnt_r > CW'(1)) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = '{lo: '0, hi: IW'(cnt_r - CW'(1))};
          sp_nxt    = SPW'(1);
        end
        state_nxt = ST_POP;
      end

      ST_POP: begin
        if (sp_r == '0) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          stk_re    = 1'b1;
          sp_nxt    = sp_r - SPW'(1);
          state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        rlo_nxt   = stk_q.lo;
        rhi_nxt   = stk_q.hi;
        lo_nxt    = stk_q.lo;
        hi_nxt    = stk_q.hi;
        mem_re    = 1'b1;
        mem_raddr = stk_q.lo;
        state_nxt = ST_PIVOT;
      end

      ST_PIVOT: begin
        pivot_nxt = mem_q;
        state_nxt = ST_RD_HI;
      end

      ST_RD_HI: begin
        if (lo_r < hi_r) begin
          mem_re    = 1'b1;
          mem_raddr = hi_r;
          state_nxt = ST_CK_HI;
        end else begin
          state_nxt = ST_PLACE;
        end
      end

      ST_CK_HI: begin
        if (mem_q >= pivot_r) begin
          hi_nxt    = hi_r - IW'(1);
          state_nxt = ST_RD_HI;
        end else begin
          // Fill the low hole with the small element
          mem_we    = 1'b1;
          mem_waddr = lo_r;
          mem_wdata = mem_q;
          state_nxt = ST_RD_LO;
        end
      end

      ST_RD_LO: begin
        if (lo_r < hi_r) begin
          mem_re    = 1'b1;
          mem_raddr = lo_r;
          state_nxt = ST_CK_LO;
        end else begin
          state_nxt = ST_PLACE;
        end
      end

      ST_CK_LO: begin
        if (mem_q <= pivot_r) begin
          lo_nxt    = lo_r + IW'(1);
          state_nxt = ST_RD_LO;
        end else begin
          // Fill the high hole with the large element
          mem_we    = 1'b1;
          mem_waddr = hi_r;
          mem_wdata = mem_q;
          state_nxt = ST_RD_HI;
        end
      end

      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = pivot_r;
        if (left_len >= CW'(2) && !sp_full) begin
          stk_we    = 1'b1;
          stk_wdata = '{lo: rlo_r, hi: lo_r - IW'(1)};
          sp_nxt    = sp_r + SPW'(1);
        end
        state_nxt = ST_PUSH_B;
      end

      ST_PUSH_B: begin
        if (right_len >= CW'(2) && !sp_full) begin
          stk_we    = 1'b1;
          stk_wdata = '{lo: lo_r + IW'(1), hi: rhi_r};
          sp_nxt    = sp_r + SPW'(1);
        end
        state_nxt = ST_POP;
      end

      ST_EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = mem_q;
        out_last_nxt  = (CW'(idx_r) == cnt_r - CW'(1));
        out_ovf_nxt   = drop_r;
        state_nxt     = ST_EMIT_WT;
      end

      ST_EMIT_WT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // Run done: clear set state for the next one
            cnt_nxt   = '0;
            sp_nxt    = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_COLLECT;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      cnt_r       <= '0;
      sp_r        <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sp_r        <= sp_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    rlo_r      <= rlo_nxt;
    rhi_r      <= rhi_nxt;
    pivot_r    <= pivot_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= elem_mem[mem_raddr];
    end
  end

  // Range stack: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_raddr];
    end
  end

  `QSS_ASSERT_NOW(a_no_input_while_emit, in_tready, !out_tvalid, "input taken while results pend")
  `QSS_ASSERT_NOW(a_stack_bound, 1'b1, sp_r <= SPW'(qss_pkg::STACK_DEPTH), "range stack overrun")
  `QSS_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CW'(qss_pkg::STORE_DEPTH), "element count overrun")
  `QSS_ASSERT_NOW(a_scan_in_range, (state_r == ST_RD_HI) || (state_r == ST_RD_LO), (lo_r <= hi_r) && (lo_r >= rlo_r) && (hi_r <= rhi_r), "scan pointers left range")
  `QSS_ASSERT_NEXT(a_run_clears, out_tvalid && out_tready && out_tlast, (cnt_r == '0) && !drop_r && in_tready, "set state not cleared after run")

endmodule

// ===== sim/quicksort_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_checker
// Watches both streams of the sorter, rebuilds each set in ascending order as
// its words are accepted, and compares every result word against it.
// ----------------------------------------------------------------------------
module quicksort_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          error_count,
  output int          pending_count
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               end_flag;
    logic               ovf;
  } sorted_word_t;

  logic signed [31:0] ordered_set[$];  // current set, kept in ascending order
  logic               set_dropped;
  sorted_word_t       sorted_expect[$];

  always @(posedge clk) begin : watch
    sorted_word_t       exp_word;
    logic signed [31:0] v;
    int                 pos;
    int                 n;
    int                 i;
    if (!rst_n) begin
      ordered_set.delete();
      sorted_expect.delete();
      set_dropped = 1'b0;
      error_count = 0;
    end else begin
      // Store the word at its sorted place, or drop it once the store is full.
      if (in_tvalid && in_tready) begin
        v = in_tdata;
        if (ordered_set.size() < qss_pkg::STORE_DEPTH) begin
          pos = 0;
          while (pos < ordered_set.size() && ordered_set[pos] <= v) pos++;
          ordered_set.insert(pos, v);
        end else begin
          set_dropped = 1'b1;
        end
        // The last word releases the whole set, greatest word marked.
        if (in_tlast) begin
          n = ordered_set.size();
          for (i = 0; i < n; i++) begin
            exp_word.value    = ordered_set[i];
            exp_word.end_flag = (i == n - 1);
            exp_word.ovf      = set_dropped;
            sorted_expect.push_back(exp_word);
          end
          ordered_set.delete();
          set_dropped = 1'b0;
        end
      end

      if (out_tvalid && out_tready) begin
        if (sorted_expect.size() == 0) begin
          $display("%0t: unexpected result word: got value %0d last %0b overflow %0b",
                   $time, $signed(out_tdata), out_tlast, out_tuser);
          error_count++;
        end else begin
          exp_word = sorted_expect.pop_front();
          if (out_tdata !== exp_word.value) begin
            $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                     $time, exp_word.value, $signed(out_tdata));
            error_count++;
          end
          if (out_tlast !== exp_word.end_flag) begin
            $display("%0t: end_of_set mismatch: expected %0b, got %0b",
                     $time, exp_word.end_flag, out_tlast);
            error_count++;
          end
          if (out_tuser !== exp_word.ovf) begin
            $display("%0t: overflow mismatch: expected %0b, got %0b",
                     $time, exp_word.ovf, out_tuser);
            error_count++;
          end
        end
      end
    end
    pending_count = sorted_expect.size();
  end

endmodule

// ===== sim/tb_quicksort_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quicksort_sorter
// Feeds sets of signed words to the sorter under changing idle and stall
// patterns; a checker beside the block predicts and compares the sorted runs.
// ----------------------------------------------------------------------------
module tb_quicksort_sorter;

  localparam int LONG_HOLD = 600;  // cycles the receiver holds off once

  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_CORNER} spread_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  // Idle and stall odds in percent, set per phase.
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   words_sent     = 0;
  int   phase_target;
  int   error_count;
  int   pending_count;

  // Long hold-off request; the receiver counts the stretch itself.
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  quicksort_sorter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  quicksort_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // Receiver: random stalls, plus one long hold-off once requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer each word of the set in turn, last word marked; hold the word until
  // it is taken, and drop valid during random gaps.
  task automatic send_list(input logic signed [31:0] vals[$]);
    int i;
    for (i = 0; i < vals.size(); i++) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= vals[i];
      in_tlast  <= (i == vals.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      words_sent++;
    end
  endtask

  // Build a set of the given length: full-range words, a narrow band full of
  // duplicates, or corner values mixed with full-range words; sometimes presorted
  // either way, which is the worst case for a first-element pivot.
  task automatic send_random_set(input int len);
    logic signed [31:0] vals[$];
    logic signed [31:0] v;
    spread_t            spread;
    int                 k;
    spread = spread_t'($urandom_range(0, 2));
    for (k = 0; k < len; k++) begin
      case (spread)
        SPREAD_FULL: begin
          v = $urandom;
        end
        SPREAD_NARROW: begin
          v = 32'($urandom_range(0, 7)) - 32'd4;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7FFF_FFFF;
            2:       v = 32'sh0000_0000;
            3:       v = -32'sd1;
            4:       v = 32'sh8000_0001;
            default: v = $urandom;
          endcase
        end
      endcase
      vals.push_back(v);
    end
    case ($urandom_range(0, 5))
      0:       vals.sort();
      1:       vals.rsort();
      default: ;
    endcase
    send_list(vals);
  endtask

  // Mostly short sets, now and then a longer one.
  task automatic send_sets_until(input int target);
    while (words_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_random_set($urandom_range(13, 40));
      else send_random_set($urandom_range(1, 12));
    end
  endtask

  // Stop offering and wait until every predicted word has come back. The
  // first edge lets the checker take in the last accepted word.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets: lone extremes, equal words, mixed signs, presorted runs.
    send_list({32'sh8000_0000});
    send_list({32'sh7FFF_FFFF, 32'sh8000_0000});
    send_list({32'sd5, 32'sd5, 32'sd5});
    send_list({32'sd1, -32'sd1, 32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send_list({-32'sd3, -32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2});
    send_list({32'sh7FFF_FFFF, 32'sd1000, 32'sd7, -32'sd7, -32'sd1000, 32'sh8000_0001});

    // Phase 1: no idling. Hold the receiver off for a long stretch so the
    // sorter backs up and stalls its input on the following set, then pause
    // the sender once until everything is back.
    hold_req <= 1'b1;
    send_random_set(6);
    phase_target = words_sent + 4;
    send_sets_until(phase_target);
    drain_results();

    // Phase 2: sender idles; one set fills the store exactly.
    send_idle_pct  = 56;
    recv_stall_pct = 0;
    send_random_set(qss_pkg::STORE_DEPTH);

    // Phase 3: receiver stalls; one set overruns the store so that the word
    // marked last is itself dropped.
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    send_random_set(qss_pkg::STORE_DEPTH + 1);

    // Phase 4: both sides idle now and then.
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    phase_target = words_sent + 10;
    send_sets_until(phase_target);

    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
